/* rtl/iqs_pkg.sv */
// Shared types for the iterative quicksort engine: input and result beats,
// and the command and status groups between controller and datapath.
// No dependencies.
package iqs_pkg;

    localparam int VALUE_W = 16;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_item;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      last_result;
        logic                      overflow;
    } t_out_item;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // take an input beat into the store
        logic push_full;  // push the whole batch range
        logic pop_rd;     // pop: read top of the range stack
        logic pop_ld;     // load bounds and pointers from the popped range
        logic cmp_rd;     // read store at both pointers
        logic step;       // advance the active pointer
        logic swap_a;     // write upper value at lower pointer
        logic swap_b;     // write lower value at upper pointer, trade direction, step
        logic push_l;     // push left subrange
        logic push_r;     // push right subrange
        logic out_rd;     // read next sorted value for output
        logic batch_done; // clear count, stack pointer, output index and drop flag
    } t_iqs_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic n_small;    // fewer than two stored elements
        logic sp_zero;    // range stack empty
        logic i_lt_j;     // pointers have not met
        logic gt;         // value at lower pointer above value at upper pointer
        logic push_l_ok;  // left subrange holds two or more elements
        logic push_r_ok;  // right subrange holds two or more elements
        logic out_last;   // output index at final element
    } t_iqs_sts;

endpackage

/* rtl/iterative_quicksort_engine_top.sv */
// Loading takes one beat per cycle while start is high in idle. After the last beat the controller checks
// the count, then per popped range loads bounds and runs compare steps, with an extra state per swap, and
// pushes subranges; once the stack drains, all n results stream out one per cycle with no gaps. The
// single-port-per-pointer element store and its registered read split each compare step into two states.
// Throughput: one batch at a time; busy drops the cycle after the final result beat.
// Reset: synchronous, active low; clears count, stack pointer, drop flag and the FSM.
module iterative_quicksort_engine_top
    import iqs_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_result
);

    // Command and status groups between controller and datapath
    t_iqs_cmd cmd;
    t_iqs_sts sts;

    // Controller: accepts a beat when start is high in idle, walks the
    // pop / partition / push loop, then streams the store out in order.
    iqs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_last  (i_item.last_item),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Datapath: hold elements and ranges, advance pointers, drive the
    // result beat in the cycle after each output read.
    iqs_dpath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_sts    (sts),
        .o_valid  (o_strobe),
        .o_result (o_result)
    );

endmodule

/* rtl/iqs_dpath.sv */
// Datapath of the quicksort engine: element store, range stack, pointers,
// counters and result register. Depends on iqs_pkg.
module iqs_dpath
    import iqs_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_iqs_cmd  i_cmd,
    input  t_in_item  i_item,
    output t_iqs_sts  o_sts,
    output logic      o_valid,
    output t_out_item o_result
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic signed [VALUE_W-1:0] r_store [MAX_ITEMS];
    logic [2*AW-1:0]           r_stack [MAX_ITEMS];

    logic [CW-1:0] r_count;
    logic [AW-1:0] r_sp;
    logic          r_dropped;
    logic [AW-1:0] r_lo, r_hi, r_i, r_j, r_out;
    logic          r_ml;
    logic signed [VALUE_W-1:0] r_rd_a, r_rd_b;
    logic [2*AW-1:0] r_stk_rd;
    logic          r_emit_vld, r_emit_last, r_emit_ovf;

    logic          full;
    logic [AW-1:0] n_last;
    logic          st_we;
    logic [AW-1:0] st_wa;
    logic signed [VALUE_W-1:0] st_wd;
    logic          sk_we;
    logic [2*AW-1:0] sk_wd;

    assign full   = (r_count >= CW'(MAX_ITEMS));
    assign n_last = AW'(r_count - CW'(1));

    always_comb begin
        st_we = 1'b0;
        st_wa = r_i;
        st_wd = r_rd_b;
        if (i_cmd.load && !full) begin
            st_we = 1'b1;
            st_wa = r_count[AW-1:0];
            st_wd = i_item.value;
        end else if (i_cmd.swap_a) begin
            st_we = 1'b1;
            st_wa = r_i;
            st_wd = r_rd_b;
        end else if (i_cmd.swap_b) begin
            st_we = 1'b1;
            st_wa = r_j;
            st_wd = r_rd_a;
        end
    end

    always_comb begin
        sk_we = i_cmd.push_full | i_cmd.push_l | i_cmd.push_r;
        sk_wd = {AW'(0), n_last};
        if (i_cmd.push_l) begin
            sk_wd = {r_lo, AW'(r_i - AW'(1))};
        end else if (i_cmd.push_r) begin
            sk_wd = {AW'(r_i + AW'(1)), r_hi};
        end
    end

    // Memories
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_wa] <= st_wd;
        end
        if (i_cmd.cmp_rd) begin
            r_rd_a <= r_store[r_i];
            r_rd_b <= r_store[r_j];
        end else if (i_cmd.out_rd) begin
            r_rd_a <= r_store[r_out];
        end
        if (sk_we) begin
            r_stack[r_sp] <= sk_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop_rd) begin
            r_stk_rd <= r_stack[AW'(r_sp - AW'(1))];
        end
    end

    // Pointers and bounds
    always_ff @(posedge i_clk) begin
        if (i_cmd.pop_ld) begin
            r_lo <= r_stk_rd[2*AW-1:AW];
            r_hi <= r_stk_rd[AW-1:0];
            r_i  <= r_stk_rd[2*AW-1:AW];
            r_j  <= r_stk_rd[AW-1:0];
            r_ml <= 1'b0;
        end else if (i_cmd.step) begin
            if (r_ml) begin
                r_i <= r_i + AW'(1);
            end else begin
                r_j <= r_j - AW'(1);
            end
        end else if (i_cmd.swap_b) begin
            r_ml <= !r_ml;
            if (!r_ml) begin
                r_i <= r_i + AW'(1);
            end else begin
                r_j <= r_j - AW'(1);
            end
        end
    end

    // Counters, flags and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sp        <= '0;
            r_dropped   <= 1'b0;
            r_out       <= '0;
            r_emit_vld  <= 1'b0;
            r_emit_last <= 1'b0;
            r_emit_ovf  <= 1'b0;
        end else begin
            if (i_cmd.batch_done) begin
                r_count   <= '0;
                r_sp      <= '0;
                r_dropped <= 1'b0;
                r_out     <= '0;
            end else begin
                if (i_cmd.load) begin
                    if (full) begin
                        r_dropped <= 1'b1;
                    end else begin
                        r_count <= r_count + CW'(1);
                    end
                end
                if (sk_we) begin
                    r_sp <= r_sp + AW'(1);
                end else if (i_cmd.pop_rd) begin
                    r_sp <= r_sp - AW'(1);
                end
                if (i_cmd.out_rd) begin
                    r_out <= r_out + AW'(1);
                end
            end
            r_emit_vld  <= i_cmd.out_rd;
            r_emit_last <= o_sts.out_last;
            r_emit_ovf  <= r_dropped;
        end
    end

    assign o_sts.n_small   = (r_count < CW'(2));
    assign o_sts.sp_zero   = (r_sp == '0);
    assign o_sts.i_lt_j    = (r_i < r_j);
    assign o_sts.gt        = (r_rd_a > r_rd_b);
    assign o_sts.push_l_ok = ({1'b0, r_i} >= ({1'b0, r_lo} + (AW+1)'(2)));
    assign o_sts.push_r_ok = (({1'b0, r_i} + (AW+1)'(1)) < {1'b0, r_hi});
    assign o_sts.out_last  = (r_out == n_last);

    assign o_valid               = r_emit_vld;
    assign o_result.sorted_value = r_rd_a;
    assign o_result.last_result  = r_emit_last;
    assign o_result.overflow     = r_emit_ovf;

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_sp} <= (AW+1)'(MAX_ITEMS / 2))
        else $error("range stack deeper than disjoint ranges allow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("item count beyond capacity");

    a_swap_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.swap_b |-> $past(i_cmd.swap_a))
        else $error("second half of swap without first half");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last_result) |=> !o_valid)
        else $error("result beat after final result of batch");
`endif

endmodule

/* rtl/iqs_ctrl.sv */
// Controller of the quicksort engine: sequences load, stack pops, partition
// steps, pushes and output. Depends on iqs_pkg.
module iqs_ctrl
    import iqs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_last,
    input  t_iqs_sts i_sts,
    output t_iqs_cmd o_cmd,
    output logic     o_busy
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK,
        ST_POP,
        ST_POP_LD,
        ST_CMP_RD,
        ST_CMP,
        ST_SWAP_B,
        ST_PUSH_L,
        ST_PUSH_R,
        ST_OUT,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_start;
                if (i_start && i_last) begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (i_sts.n_small) begin
                    n_state = ST_OUT;
                end else begin
                    o_cmd.push_full = 1'b1;
                    n_state         = ST_POP;
                end
            end
            ST_POP: begin
                if (i_sts.sp_zero) begin
                    n_state = ST_OUT;
                end else begin
                    o_cmd.pop_rd = 1'b1;
                    n_state      = ST_POP_LD;
                end
            end
            ST_POP_LD: begin
                o_cmd.pop_ld = 1'b1;
                n_state      = ST_CMP_RD;
            end
            ST_CMP_RD: begin
                if (i_sts.i_lt_j) begin
                    o_cmd.cmp_rd = 1'b1;
                    n_state      = ST_CMP;
                end else begin
                    n_state = ST_PUSH_L;
                end
            end
            ST_CMP: begin
                if (i_sts.gt) begin
                    o_cmd.swap_a = 1'b1;
                    n_state      = ST_SWAP_B;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_CMP_RD;
                end
            end
            ST_SWAP_B: begin
                o_cmd.swap_b = 1'b1;
                n_state      = ST_CMP_RD;
            end
            ST_PUSH_L: begin
                o_cmd.push_l = i_sts.push_l_ok;
                n_state      = ST_PUSH_R;
            end
            ST_PUSH_R: begin
                o_cmd.push_r = i_sts.push_r_ok;
                n_state      = ST_POP;
            end
            ST_OUT: begin
                o_cmd.out_rd = 1'b1;
                if (i_sts.out_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_cmd.batch_done = 1'b1;
                n_state          = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != ST_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule
